// ===== rtl/occupancy_frontier_cell_classifier_macros.svh =====
// Assertion macros shared by the classifier modules.
`ifndef OCCUPANCY_FRONTIER_CELL_CLASSIFIER_MACROS_SVH
`define OCCUPANCY_FRONTIER_CELL_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
`define OFC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ofc assertion failed");
`define OFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ofc assertion failed");
`else
`define OFC_ASSERT_IMP(label, clk, rst, ante, cons)
`define OFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/ofc_pkg.sv =====
package ofc_pkg;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int VAL_W     = 8;
  localparam int BOUND_W   = 7;
  localparam int IDX_W     = 24;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNEXPLORED_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNEXPLORED_HIGH = 2'd3;

  localparam logic [CFG_W-1:0]   GRID_WIDTH_RST      = 13'd4096;
  localparam logic [CFG_W-1:0]   GRID_HEIGHT_RST     = 13'd4096;
  localparam logic [BOUND_W-1:0] UNEXPLORED_LOW_RST  = 7'd30;
  localparam logic [BOUND_W-1:0] UNEXPLORED_HIGH_RST = 7'd65;

  localparam logic signed [VAL_W-1:0] FREE_MAX    = 8'sd30;
  localparam logic signed [VAL_W-1:0] UNKNOWN_VAL = -8'sd1;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic                    drain;
  } cell_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic             frontier;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic [BOUND_W-1:0] low;
    logic [BOUND_W-1:0] high;
  } bounds_t;

  // Per-item position flags worked out when the item enters.
  typedef struct packed {
    logic produce;
    logic last;
    logic has_l;
    logic has_r;
    logic has_t;
    logic has_b;
  } scan_ctl_t;

  function automatic logic is_unmapped(logic signed [VAL_W-1:0] v, bounds_t b);
    logic signed [VAL_W:0] vx;
    logic signed [VAL_W:0] lo;
    logic signed [VAL_W:0] hi;
    vx = {v[VAL_W-1], v};
    lo = $signed({2'b00, b.low});
    hi = $signed({2'b00, b.high});
    return (v == UNKNOWN_VAL) || ((vx > lo) && (vx < hi));
  endfunction

  function automatic logic is_free(logic signed [VAL_W-1:0] v);
    return !v[VAL_W-1] && (v <= FREE_MAX);
  endfunction

endpackage

// ===== rtl/ofc_cfg.sv =====
module ofc_cfg #(
  parameter int MAX_WIDTH  = ofc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ofc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ofc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ofc_pkg::CFG_W-1:0]      cfg_data,
  output logic [$clog2(MAX_WIDTH+1)-1:0]  width,
  output logic [$clog2(MAX_HEIGHT+1)-1:0] height,
  output ofc_pkg::bounds_t               bounds,
  output logic                           restart
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Sizes are stored already clamped to 1..max.
  function automatic logic [WW-1:0] clamp_w(logic [ofc_pkg::CFG_W-1:0] raw);
    logic [31:0] r;
    r = 32'(raw);
    if (r == 32'd0) return WW'(1);
    if (r > 32'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return WW'(r);
  endfunction

  function automatic logic [HW-1:0] clamp_h(logic [ofc_pkg::CFG_W-1:0] raw);
    logic [31:0] r;
    r = 32'(raw);
    if (r == 32'd0) return HW'(1);
    if (r > 32'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
    return HW'(r);
  endfunction

  assign restart = cfg_we && ((cfg_index == ofc_pkg::REG_GRID_WIDTH) ||
                              (cfg_index == ofc_pkg::REG_GRID_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      width       <= clamp_w(ofc_pkg::GRID_WIDTH_RST);
      height      <= clamp_h(ofc_pkg::GRID_HEIGHT_RST);
      bounds.low  <= ofc_pkg::UNEXPLORED_LOW_RST;
      bounds.high <= ofc_pkg::UNEXPLORED_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ofc_pkg::REG_GRID_WIDTH:      width       <= clamp_w(cfg_data);
        ofc_pkg::REG_GRID_HEIGHT:     height      <= clamp_h(cfg_data);
        ofc_pkg::REG_UNEXPLORED_LOW:  bounds.low  <= cfg_data[ofc_pkg::BOUND_W-1:0];
        ofc_pkg::REG_UNEXPLORED_HIGH: bounds.high <= cfg_data[ofc_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ofc_scan.sv =====
`include "occupancy_frontier_cell_classifier_macros.svh"

module ofc_scan #(
  parameter int MAX_WIDTH  = ofc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ofc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            restart,
  input  logic                            accept,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height,
  output logic [$clog2(MAX_WIDTH)-1:0]    col,
  output ofc_pkg::scan_ctl_t              ctl
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [RW-1:0] row;
  logic [31:0]   c32, r32, w32, h32;

  assign c32 = 32'(col);
  assign r32 = 32'(row);
  assign w32 = 32'(width);
  assign h32 = 32'(height);

  // Flags for the cell centered one row and one column behind this item.
  always_comb begin
    ctl.produce = (r32 >= 32'd2) || ((r32 == 32'd1) && (c32 >= 32'd1));
    ctl.last    = (r32 == h32 + 32'd1) && (c32 == 32'd0);
    ctl.has_l   = (c32 >= 32'd2) || ((c32 == 32'd0) && (w32 > 32'd1));
    ctl.has_r   = (c32 >= 32'd1);
    ctl.has_t   = (c32 >= 32'd1) ? (r32 >= 32'd2) : (r32 >= 32'd3);
    ctl.has_b   = (c32 >= 32'd1) ? (r32 < h32) : (r32 <= h32);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (ctl.last) begin
        col <= '0;
        row <= '0;
      end else if (c32 + 32'd1 >= w32) begin
        col <= '0;
        row <= RW'(r32 + 32'd1);
      end else begin
        col <= CW'(c32 + 32'd1);
      end
    end
  end

  `OFC_ASSERT_NEXT(a_scan_wrap, clk, rst, accept && ctl.last && !restart, col == '0 && row == '0)
  `OFC_ASSERT_IMP(a_last_produces, clk, rst, ctl.last, ctl.produce)
  `OFC_ASSERT_IMP(a_col_in_grid, clk, rst, 1'b1, c32 < w32)

endmodule

// ===== rtl/ofc_row_mem.sv =====
module ofc_row_mem #(
  parameter int DEPTH = ofc_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [2*ofc_pkg::VAL_W-1:0] wdata,
  output logic [2*ofc_pkg::VAL_W-1:0] rdata
);

  // Upper and middle row stores share one word per column: {upper, middle}.
  logic [2*ofc_pkg::VAL_W-1:0] mem [DEPTH];
  logic [2*ofc_pkg::VAL_W-1:0] rd;
  logic [2*ofc_pkg::VAL_W-1:0] fwd_data;
  logic                        fwd_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read that meets a write to the same column takes the new word.
  always_ff @(posedge clk) begin
    if (re) begin
      rd       <= mem[raddr];
      fwd_hit  <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
  end

  assign rdata = fwd_hit ? fwd_data : rd;

endmodule

// ===== rtl/ofc_window.sv =====
`include "occupancy_frontier_cell_classifier_macros.svh"

module ofc_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic                           fire,
  input  logic signed [ofc_pkg::VAL_W-1:0] fresh,
  input  ofc_pkg::scan_ctl_t             ctl,
  input  ofc_pkg::bounds_t               bounds,
  input  logic [2*ofc_pkg::VAL_W-1:0]    rdata,
  output logic [2*ofc_pkg::VAL_W-1:0]    wdata,
  output ofc_pkg::result_t               res
);

  localparam int IW = ofc_pkg::IDX_W;

  // win[0..2]: left column top/mid/bottom, win[3..5]: center column.
  logic signed [ofc_pkg::VAL_W-1:0] win [6];
  logic signed [ofc_pkg::VAL_W-1:0] right0, right1, right2;
  logic [ofc_pkg::IDX_W-1:0]        pos;
  logic                             hit;

  assign right0 = $signed(rdata[2*ofc_pkg::VAL_W-1:ofc_pkg::VAL_W]);
  assign right1 = $signed(rdata[ofc_pkg::VAL_W-1:0]);
  assign right2 = fresh;
  assign wdata  = {right1, fresh};

  always_comb begin
    hit = 1'b0;
    if (ctl.has_l && ofc_pkg::is_unmapped(win[1], bounds)) hit = 1'b1;
    if (ctl.has_l && ctl.has_t && ofc_pkg::is_unmapped(win[0], bounds)) hit = 1'b1;
    if (ctl.has_l && ctl.has_b && ofc_pkg::is_unmapped(win[2], bounds)) hit = 1'b1;
    if (ctl.has_r && ofc_pkg::is_unmapped(right1, bounds)) hit = 1'b1;
    if (ctl.has_r && ctl.has_t && ofc_pkg::is_unmapped(right0, bounds)) hit = 1'b1;
    if (ctl.has_r && ctl.has_b && ofc_pkg::is_unmapped(right2, bounds)) hit = 1'b1;
    if (ctl.has_t && ofc_pkg::is_unmapped(win[3], bounds)) hit = 1'b1;
    if (ctl.has_b && ofc_pkg::is_unmapped(win[5], bounds)) hit = 1'b1;
  end

  assign res.cell_index = pos;
  assign res.frontier   = ofc_pkg::is_free(win[4]) && hit;
  assign res.frame_end  = ctl.last;

  always_ff @(posedge clk) begin
    if (rst || restart || (fire && ctl.last)) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
      pos <= '0;
    end else if (fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= right0;
      win[4] <= right1;
      win[5] <= right2;
      if (ctl.produce) begin
        pos <= pos + IW'(1);
      end
    end
  end

  `OFC_ASSERT_NEXT(a_pos_clear, clk, rst, fire && ctl.last, pos == '0)
  `OFC_ASSERT_NEXT(a_pos_hold, clk, rst, !fire && !restart, $stable(pos))

endmodule

// ===== rtl/occupancy_frontier_cell_classifier.sv =====
// Frontier classifier for a raster occupancy grid: one cell per cycle in, one
// result per item out once one row and two cells have arrived. Each cell is
// judged on its 3x3 neighborhood held in a dual row store (one synchronous
// memory of MAX_WIDTH words, read as the item enters and written back as the
// item leaves the read stage) and a six-byte window; results trail the input
// by one row and one column, so after the last cell send width+1 drain items.
// The result an item causes passes from the item stage into the output
// register when the output advances; throughput is one item per cycle, limited
// only by output stall. No clearing pass: unwritten store entries only feed
// out-of-grid neighbors, which are masked. Writing the grid width or height
// restarts the frame.
`include "occupancy_frontier_cell_classifier_macros.svh"

module occupancy_frontier_cell_classifier #(
  parameter int MAX_WIDTH  = ofc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ofc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cell_valid,
  output logic                          cell_stall,
  input  ofc_pkg::cell_t                grid_cell,
  output logic                          result_valid,
  input  logic                          result_stall,
  output ofc_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [ofc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ofc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0]      width;
  logic [HW-1:0]      height;
  ofc_pkg::bounds_t   bounds;
  logic               restart;

  logic               adv;
  logic               accept;
  logic [CW-1:0]      col;
  ofc_pkg::scan_ctl_t ctl;

  logic                             s1_valid;
  logic signed [ofc_pkg::VAL_W-1:0] s1_fresh;
  logic [CW-1:0]                    s1_col;
  ofc_pkg::scan_ctl_t               s1_ctl;
  logic                             fire;

  logic [2*ofc_pkg::VAL_W-1:0] rdata;
  logic [2*ofc_pkg::VAL_W-1:0] wdata;
  ofc_pkg::result_t            s1_res;

  assign adv        = !result_valid || !result_stall;
  assign cell_stall = !adv;
  assign accept     = cell_valid && adv;
  assign fire       = s1_valid && adv;

  ofc_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .width, .height, .bounds, .restart
  );

  ofc_scan #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_scan (
    .clk, .rst, .restart, .accept, .width, .height, .col, .ctl
  );

  ofc_row_mem #(.DEPTH(MAX_WIDTH), .AW(CW)) u_mem (
    .clk,
    .re    (accept),
    .raddr (col),
    .we    (fire),
    .waddr (s1_col),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Item stage: payload lines up with the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fresh <= grid_cell.drain ? '0 : grid_cell.cell_value;
      s1_col   <= col;
      s1_ctl   <= ctl;
    end
  end

  ofc_window u_window (
    .clk, .rst, .restart, .fire,
    .fresh  (s1_fresh),
    .ctl    (s1_ctl),
    .bounds (bounds),
    .rdata  (rdata),
    .wdata  (wdata),
    .res    (s1_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s1_valid && s1_ctl.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= s1_res;
    end
  end

  `OFC_ASSERT_IMP(a_stall_cause, clk, rst, cell_stall, result_valid && result_stall)
  `OFC_ASSERT_NEXT(a_result_issue, clk, rst, fire && s1_ctl.produce, result_valid)
  `OFC_ASSERT_NEXT(a_no_phantom, clk, rst, adv && !(s1_valid && s1_ctl.produce), !result_valid)

endmodule

// ===== test/occupancy_frontier_cell_classifier_test.sv =====
`timescale 1ns / 100ps

module occupancy_frontier_cell_classifier_test;

  localparam int GRID_MAX     = 4096;
  localparam int GRID_AW      = $clog2(GRID_MAX);
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 130;
  localparam int VW           = ofc_pkg::VAL_W;
  localparam int IW           = ofc_pkg::IDX_W;
  localparam int CFW          = ofc_pkg::CFG_W;
  localparam int BW           = ofc_pkg::BOUND_W;
  localparam int XW           = ofc_pkg::CFG_IDX_W;

  logic             clk;
  logic             rst;
  logic             cell_valid;
  logic             cell_stall;
  ofc_pkg::cell_t   grid_cell;
  logic             result_valid;
  logic             result_stall;
  ofc_pkg::result_t result;
  logic             cfg_we;
  logic [XW-1:0]    cfg_index;
  logic [CFW-1:0]   cfg_data;

  occupancy_frontier_cell_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .grid_cell    (grid_cell),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Frontier predictor state
  logic [VW-1:0]      upper_line [GRID_MAX];
  logic [VW-1:0]      middle_line [GRID_MAX];
  logic [VW-1:0]      win [6];      // left col 0..2, center col 3..5, top to bottom
  int unsigned        col_pos;
  int unsigned        row_pos;
  int unsigned        next_index;
  logic [CFW-1:0]     width_reg;
  logic [CFW-1:0]     height_reg;
  logic [BW-1:0]      bound_lo;
  logic [BW-1:0]      bound_hi;
  ofc_pkg::result_t   expected_results[$];

  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int max_gap = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned used_size(logic [CFW-1:0] raw);
    int unsigned r;
    r = 32'(raw);
    if (r == 0) return 1;
    if (r > GRID_MAX) return GRID_MAX;
    return r;
  endfunction

  function automatic bit looks_unexplored(logic [VW-1:0] raw);
    int v;
    v = int'($signed(raw));
    return (v == int'(ofc_pkg::UNKNOWN_VAL)) ||
           (v > int'(bound_lo) && v < int'(bound_hi));
  endfunction

  function automatic ofc_pkg::cell_t make_cell(logic [VW-1:0] v, logic d);
    ofc_pkg::cell_t c;
    c.cell_value = v;
    c.drain = d;
    return c;
  endfunction

  function automatic logic [VW-1:0] random_occupancy();
    case ($urandom_range(3))
      0: return ofc_pkg::UNKNOWN_VAL;
      1: return VW'($urandom_range(0, int'(ofc_pkg::FREE_MAX)));
      2: return VW'($urandom_range(31, 100));
      default: return VW'($urandom());
    endcase
  endfunction

  task automatic clear_frame();
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
    next_index = 0;
  endtask

  task automatic apply_reg(logic [XW-1:0] idx, logic [CFW-1:0] data);
    case (idx)
      ofc_pkg::REG_GRID_WIDTH: begin
        width_reg = data;
        clear_frame();
      end
      ofc_pkg::REG_GRID_HEIGHT: begin
        height_reg = data;
        clear_frame();
      end
      ofc_pkg::REG_UNEXPLORED_LOW: bound_lo = data[BW-1:0];
      ofc_pkg::REG_UNEXPLORED_HIGH: bound_hi = data[BW-1:0];
      default: ;
    endcase
  endtask

  // Classify the cell whose lower-right neighbor is this item, if any.
  task automatic classify_cell(ofc_pkg::cell_t c);
    int unsigned w, h, col, cx, cy, total;
    logic [GRID_AW-1:0] ci;
    logic [VW-1:0] fresh;
    logic [VW-1:0] right [3];
    bit has_l, has_r, has_t, has_b, hit, last;
    int centre;
    ofc_pkg::result_t r;
    w = used_size(width_reg);
    h = used_size(height_reg);
    fresh = c.drain ? '0 : c.cell_value;
    col = (col_pos >= w) ? w - 1 : col_pos;
    ci = GRID_AW'(col);
    right[0] = upper_line[ci];
    right[1] = middle_line[ci];
    right[2] = fresh;
    upper_line[ci] = right[1];
    middle_line[ci] = fresh;
    if (row_pos >= 2 || (row_pos == 1 && col >= 1)) begin
      cx = (col >= 1) ? col - 1 : w - 1;
      cy = (col >= 1) ? row_pos - 1 : row_pos - 2;
      has_l = cx > 0;
      has_r = col >= 1;
      has_t = cy > 0;
      has_b = cy + 1 < h;
      centre = int'($signed(win[4]));
      hit = 1'b0;
      if (centre >= 0 && centre <= int'(ofc_pkg::FREE_MAX)) begin
        hit = (has_l && looks_unexplored(win[1])) ||
              (has_l && has_t && looks_unexplored(win[0])) ||
              (has_l && has_b && looks_unexplored(win[2])) ||
              (has_r && looks_unexplored(right[1])) ||
              (has_r && has_t && looks_unexplored(right[0])) ||
              (has_r && has_b && looks_unexplored(right[2])) ||
              (has_t && looks_unexplored(win[3])) ||
              (has_b && looks_unexplored(win[5]));
      end
      total = w * h;
      last = (next_index + 1 >= total);
      r.cell_index = IW'(next_index);
      r.frontier = hit;
      r.frame_end = last;
      expected_results = {expected_results, r};
      if (last) begin
        clear_frame();
        return;
      end
      next_index++;
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = right[0];
    win[4] = right[1];
    win[5] = right[2];
    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos = col + 1;
    end
  endtask

  // Offer one item, holding it until accepted; bursts with random gaps.
  task automatic send_cell(ofc_pkg::cell_t c);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (max_gap > 0) gap = $urandom_range(0, max_gap);
    end
    burst_left--;
    if (gap > 0) begin
      cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_valid <= 1'b1;
    grid_cell <= c;
    do @(posedge clk); while (cell_stall);
    classify_cell(c);
    items_sent++;
  endtask

  task automatic send_grid(int cells, int pads, int cell_drain_pct, int pad_drain_pct);
    for (int i = 0; i < cells; i++)
      send_cell(make_cell(random_occupancy(), $urandom_range(99) < cell_drain_pct));
    for (int i = 0; i < pads; i++)
      send_cell(make_cell(VW'($urandom()), $urandom_range(99) < pad_drain_pct));
  endtask

  task automatic wait_quiet();
    cell_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [XW-1:0] idx, logic [CFW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(int w, int h);
    wait_quiet();
    write_reg(ofc_pkg::REG_GRID_WIDTH, CFW'(w));
    write_reg(ofc_pkg::REG_GRID_HEIGHT, CFW'(h));
  endtask

  task automatic set_bounds(int lo, int hi);
    wait_quiet();
    write_reg(ofc_pkg::REG_UNEXPLORED_LOW, CFW'(lo));
    write_reg(ofc_pkg::REG_UNEXPLORED_HIGH, CFW'(hi));
  endtask

  // Small hand-built grids under the reset bounds: value extremes, drain inside
  // a frame, non-drain padding, single-cell grid.
  task automatic test_directed();
    int grid_a [9] = '{int'(ofc_pkg::UNKNOWN_VAL), 0, 30, 31, 0, 64, 65, 127, -128};
    max_gap = 0;
    stall_pct = 0;
    set_grid(3, 3);
    foreach (grid_a[i]) send_cell(make_cell(VW'(grid_a[i]), 1'b0));
    for (int i = 0; i < 4; i++) send_cell(make_cell(8'h7F, 1'b1));
    set_grid(2, 2);
    send_cell(make_cell(8'h00, 1'b0));
    send_cell(make_cell(ofc_pkg::UNKNOWN_VAL, 1'b1));
    send_cell(make_cell(ofc_pkg::UNKNOWN_VAL, 1'b0));
    send_cell(make_cell(8'd31, 1'b0));
    send_cell(make_cell(ofc_pkg::UNKNOWN_VAL, 1'b0));
    send_cell(make_cell(8'h80, 1'b1));
    send_cell(make_cell(8'h55, 1'b1));
    set_grid(1, 1);
    send_cell(make_cell(8'h00, 1'b0));
    send_cell(make_cell(ofc_pkg::UNKNOWN_VAL, 1'b1));
    send_cell(make_cell(ofc_pkg::UNKNOWN_VAL, 1'b1));
  endtask

  // Out-of-range sizes clamp: zero sizes are used as one, an oversized
  // height runs as a tall single column.
  task automatic test_size_extremes();
    max_gap = 2;
    stall_pct = 20;
    set_grid(0, 0);
    send_grid(1, 2, 0, 50);
    set_grid(0, 13'h1FFF);
    send_grid(60, 0, 2, 50);
    set_grid(4, 0);
    send_grid(4, 5, 2, 50);
  endtask

  task automatic test_bound_settings();
    int lows [6]  = '{0, 0, 100, 100, 0, 29};
    int highs [6] = '{0, 100, 0, 100, 127, 31};
    int w, h;
    max_gap = 4;
    stall_pct = 40;
    foreach (lows[i]) begin
      w = $urandom_range(3, 6);
      h = $urandom_range(3, 5);
      set_bounds(lows[i], highs[i]);
      set_grid(w, h);
      send_grid(w * h, w + 1, 3, 80);
    end
    set_bounds(30, 65);
  endtask

  // Back-to-back frames, padding without drain, frames cut short by a size write.
  task automatic test_restart_and_padding();
    max_gap = 3;
    stall_pct = 30;
    set_grid(5, 4);
    send_grid(20, 6, 0, 100);
    send_grid(20, 6, 0, 100);
    send_grid(20, 6, 0, 0);
    send_grid(7, 0, 10, 0);
    set_grid(13'h1FFF, 2);
    send_grid(20, 0, 10, 0);
    set_grid(4, 4);
    send_grid(16, 5, 10, 50);
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_output_hold();
    max_gap = 0;
    stall_pct = 0;
    set_grid(8, 6);
    hold_request = 1'b1;
    send_grid(48, 9, 0, 100);
  endtask

  task automatic test_random_frames();
    int start, w, h;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 6);
      case ($urandom_range(3))
        0: begin
          max_gap = 0;
          stall_pct = 0;
        end
        1: begin
          max_gap = 3;
          stall_pct = 30;
        end
        2: begin
          max_gap = 10;
          stall_pct = 60;
        end
        default: begin
          max_gap = 1;
          stall_pct = 10;
        end
      endcase
      if ($urandom_range(3) == 0)
        set_bounds(int'($urandom_range(0, 100)), int'($urandom_range(0, 100)));
      set_grid(w, h);
      if ($urandom_range(9) < 8)
        send_grid(w * h, w + 1, 5, 70);
      else
        send_grid($urandom_range(1, w * h + w), 0, 20, 50);
    end
  endtask

  initial begin
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    width_reg = ofc_pkg::GRID_WIDTH_RST;
    height_reg = ofc_pkg::GRID_HEIGHT_RST;
    bound_lo = ofc_pkg::UNEXPLORED_LOW_RST;
    bound_hi = ofc_pkg::UNEXPLORED_HIGH_RST;
    clear_frame();
    rst <= 1'b1;
    cell_valid <= 1'b0;
    grid_cell <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_size_extremes();
    test_bound_settings();
    test_restart_and_padding();
    test_output_hold();
    test_random_frames();
    wait_quiet();
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Receiver: stall runs of random length, plus one long hold on request.
  initial begin : receiver
    int run_left;
    bit stalled_now;
    bit hold_done;
    run_left = 0;
    stalled_now = 1'b0;
    hold_done = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (run_left == 0) begin
        stalled_now = ($urandom_range(99) < stall_pct);
        run_left = $urandom_range(1, 6);
      end
      run_left--;
      result_stall <= stalled_now;
    end
  end

  task automatic flag(string what, logic [31:0] want_v, logic [31:0] got_v);
    errors++;
    if (errors <= 20) $display("%0t %s: expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : result_check
    ofc_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t unexpected item: expected none, got index %0d", $time,
                   result.cell_index);
      end else begin
        want = expected_results.pop_front();
        if (result.cell_index !== want.cell_index)
          flag("cell_index", 32'(want.cell_index), 32'(result.cell_index));
        if (result.frontier !== want.frontier)
          flag("frontier", 32'(want.frontier), 32'(result.frontier));
        if (result.frame_end !== want.frame_end)
          flag("frame_end", 32'(want.frame_end), 32'(result.frame_end));
      end
    end
  end

  // Ends the run if no item moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((cell_valid && !cell_stall) || (result_valid && !result_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

// ===== occupancy_frontier_cell_classifier.f =====
+incdir+rtl
rtl/ofc_pkg.sv
rtl/ofc_cfg.sv
rtl/ofc_scan.sv
rtl/ofc_row_mem.sv
rtl/ofc_window.sv
rtl/occupancy_frontier_cell_classifier.sv
test/occupancy_frontier_cell_classifier_test.sv
